@@ design/pfi_pkg.sv @@
`default_nettype none
package pfi_pkg;

  // Instruction word layout widths
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned SKIP_W  = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned INSN_W  = CODE_W + 2 * SKIP_W + WORD_W;
  localparam int unsigned PLEN_W  = 7;
  // Program counter: entry count plus forward jumps of up to 2^32
  localparam int unsigned PC_W    = 34;
  // Header length nibble mask
  localparam logic [3:0]  NIB_MASK = 4'hf;

  // Opcodes that stand alone
  localparam logic [CODE_W-1:0] OP_LD_IMM   = 16'h0000;
  localparam logic [CODE_W-1:0] OP_LDX_IMM  = 16'h0001;
  localparam logic [CODE_W-1:0] OP_ST       = 16'h0002;
  localparam logic [CODE_W-1:0] OP_STX      = 16'h0003;
  localparam logic [CODE_W-1:0] OP_JA       = 16'h0005;
  localparam logic [CODE_W-1:0] OP_RET_K    = 16'h0006;
  localparam logic [CODE_W-1:0] OP_TAX      = 16'h0007;
  localparam logic [CODE_W-1:0] OP_RET_A    = 16'h0016;
  localparam logic [CODE_W-1:0] OP_LD_ABS_W = 16'h0020;
  localparam logic [CODE_W-1:0] OP_LD_ABS_H = 16'h0028;
  localparam logic [CODE_W-1:0] OP_LD_ABS_B = 16'h0030;
  localparam logic [CODE_W-1:0] OP_LD_IND_W = 16'h0040;
  localparam logic [CODE_W-1:0] OP_LD_IND_H = 16'h0048;
  localparam logic [CODE_W-1:0] OP_LD_IND_B = 16'h0050;
  localparam logic [CODE_W-1:0] OP_LD_MEM   = 16'h0060;
  localparam logic [CODE_W-1:0] OP_LDX_MEM  = 16'h0061;
  localparam logic [CODE_W-1:0] OP_LD_LEN   = 16'h0080;
  localparam logic [CODE_W-1:0] OP_LDX_LEN  = 16'h0081;
  localparam logic [CODE_W-1:0] OP_NEG      = 16'h0084;
  localparam logic [CODE_W-1:0] OP_TXA      = 16'h0087;
  localparam logic [CODE_W-1:0] OP_LDX_MSH  = 16'h00b1;

  // Conditional jumps
  localparam logic [CODE_W-1:0] OP_JEQ_K  = 16'h0015;
  localparam logic [CODE_W-1:0] OP_JEQ_X  = 16'h001d;
  localparam logic [CODE_W-1:0] OP_JGT_K  = 16'h0025;
  localparam logic [CODE_W-1:0] OP_JGT_X  = 16'h002d;
  localparam logic [CODE_W-1:0] OP_JGE_K  = 16'h0035;
  localparam logic [CODE_W-1:0] OP_JGE_X  = 16'h003d;
  localparam logic [CODE_W-1:0] OP_JSET_K = 16'h0045;
  localparam logic [CODE_W-1:0] OP_JSET_X = 16'h004d;

  // ALU group: class ALU, any op, K or X source
  localparam logic [2:0] CLS_ALU = 3'b100;

  // Op field codes (bits 6:4)
  localparam logic [2:0] ALU_ADD = 3'd0;
  localparam logic [2:0] ALU_SUB = 3'd1;
  localparam logic [2:0] ALU_MUL = 3'd2;
  localparam logic [2:0] ALU_DIV = 3'd3;
  localparam logic [2:0] ALU_OR  = 3'd4;
  localparam logic [2:0] ALU_AND = 3'd5;
  localparam logic [2:0] ALU_LSH = 3'd6;
  localparam logic [2:0] ALU_RSH = 3'd7;
  localparam logic [2:0] JMP_EQ  = 3'd1;
  localparam logic [2:0] JMP_GT  = 3'd2;
  localparam logic [2:0] JMP_GE  = 3'd3;

  // Packet load sizes in bytes
  localparam logic [2:0] SZ_W = 3'd4;
  localparam logic [2:0] SZ_H = 3'd2;
  localparam logic [2:0] SZ_B = 3'd1;

endpackage
`default_nettype wire

@@ design/packet_filter_interpreter_core.sv @@
// Packet filter core: bytes and program writes are taken one per cycle.
// After the item flagged last, the program runs on one shared ALU under a
// sequencer that fetches, then executes each instruction; packet loads read
// byte by byte, scratch loads add a read, divides step per quotient bit, and
// the verdict is registered last. Input stalls during the run. Synchronous
// active-low reset clears control state and scratch valid bits, not stores.
`default_nettype none
module packet_filter_interpreter_core
  import pfi_pkg::*;
#(
  parameter int unsigned PROGRAM_DEPTH = 64,
  parameter int unsigned PACKET_BYTES  = 2048,
  parameter int unsigned SCRATCH_WORDS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic [5:0]  in_instr_index,
  input  wire logic [15:0] in_instr_code,
  input  wire logic [7:0]  in_jump_true,
  input  wire logic [7:0]  in_jump_false,
  input  wire logic [31:0] in_constant_k,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_return_value,
  output logic             out_accepted,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_data
);

  localparam int unsigned PW  = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
  localparam int unsigned AW  = $clog2(PACKET_BYTES);
  localparam int unsigned LW  = $clog2(PACKET_BYTES + 1);
  localparam int unsigned SW  = (SCRATCH_WORDS > 1) ? $clog2(SCRATCH_WORDS) : 1;
  localparam int unsigned DCW = $clog2(WORD_W);

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_EXEC, S_LDADDR, S_LDDATA, S_SCR, S_DIV, S_DONE
  } state_t;

  state_t              state_r;
  logic [PLEN_W-1:0]   plen_r;
  logic [LW-1:0]       pkt_len_r;
  logic [PC_W-1:0]     pc_r;
  logic [WORD_W-1:0]   a_r, x_r;
  logic [WORD_W-1:0]   result_r;
  logic                out_valid_r;
  logic [WORD_W-1:0]   out_value_r;
  logic [INSN_W-1:0]   insn_q_r;
  logic [7:0]          pkt_q_r;
  logic [AW-1:0]       ld_addr_r;
  logic [2:0]          ld_left_r;
  logic [WORD_W-1:0]   ld_val_r;
  logic                ld_to_x_r;
  logic                ld_msh_r;
  logic [WORD_W-1:0]   scr_q_r;
  logic                scr_qv_r;
  logic [SCRATCH_WORDS-1:0] scr_vld_r;
  logic [WORD_W-1:0]   div_rem_r, div_quo_r, div_dvs_r;
  logic [DCW-1:0]      div_cnt_r;

  logic [INSN_W-1:0]   prog_mem [PROGRAM_DEPTH];
  logic [7:0]          pkt_mem  [PACKET_BYTES];
  logic [WORD_W-1:0]   scr_mem  [SCRATCH_WORDS];

  // Input handshake
  logic in_acc, prog_wr, byte_wr, run_start;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign prog_wr   = in_acc && !in_operation && (32'(in_instr_index) < PROGRAM_DEPTH);
  assign byte_wr   = in_acc && in_operation && (pkt_len_r < LW'(PACKET_BYTES));
  assign run_start = in_acc && in_operation && in_last_byte;
  assign cfg_ready = 1'b1;

  // Instruction fields
  logic [CODE_W-1:0] code;
  logic [SKIP_W-1:0] jt, jf;
  logic [WORD_W-1:0] k, t;
  assign {code, jt, jf, k} = insn_q_r;
  assign t = code[3] ? x_r : k;

  // Fetch bound
  logic [PC_W-1:0] limit;
  assign limit = (32'(plen_r) > PROGRAM_DEPTH) ? PC_W'(PROGRAM_DEPTH) : PC_W'(plen_r);

  // Packet load bound check
  logic [2:0]      ld_size;
  logic            ld_ind;
  logic [PC_W-1:0] ld_off, ld_end;
  always_comb begin
    ld_size = SZ_B;
    ld_ind  = 1'b0;
    case (code)
      OP_LD_ABS_W: ld_size = SZ_W;
      OP_LD_ABS_H: ld_size = SZ_H;
      OP_LD_IND_W: begin ld_size = SZ_W; ld_ind = 1'b1; end
      OP_LD_IND_H: begin ld_size = SZ_H; ld_ind = 1'b1; end
      OP_LD_IND_B: ld_ind = 1'b1;
      default:     ld_size = SZ_B;
    endcase
  end
  assign ld_off = PC_W'(k) + (ld_ind ? PC_W'(x_r) : '0);
  assign ld_end = ld_off + PC_W'(ld_size);

  // Shared ALU and compare unit
  logic [WORD_W-1:0] alu_y;
  logic              cond;
  logic [2:0]        opf;
  logic [WORD_W:0]   div_trial;
  assign opf = code[6:4];
  always_comb begin
    case (opf)
      ALU_ADD: alu_y = a_r + t;
      ALU_SUB: alu_y = a_r - t;
      ALU_MUL: alu_y = a_r * t;
      ALU_OR:  alu_y = a_r | t;
      ALU_AND: alu_y = a_r & t;
      ALU_LSH: alu_y = (t >= WORD_W) ? '0 : (a_r << t[DCW-1:0]);
      ALU_RSH: alu_y = (t >= WORD_W) ? '0 : (a_r >> t[DCW-1:0]);
      default: alu_y = a_r;
    endcase
    case (opf)
      JMP_EQ:  cond = (a_r == t);
      JMP_GT:  cond = (a_r > t);
      JMP_GE:  cond = (a_r >= t);
      default: cond = ((a_r & t) != '0);
    endcase
  end
  assign div_trial = {div_rem_r, div_quo_r[WORD_W-1]} - {1'b0, div_dvs_r};

  // Next program counter: one step, plus the skip for jumps
  logic [PC_W-1:0] pc_nxt;
  always_comb begin
    case (code)
      OP_JA: pc_nxt = pc_r + PC_W'(1) + PC_W'(k);
      OP_JEQ_K, OP_JEQ_X, OP_JGT_K, OP_JGT_X,
      OP_JGE_K, OP_JGE_X, OP_JSET_K, OP_JSET_X:
        pc_nxt = pc_r + PC_W'(1) + PC_W'(cond ? jt : jf);
      default: pc_nxt = pc_r + PC_W'(1);
    endcase
  end

  logic k_scr_ok;
  logic [SW-1:0] k_scr;
  assign k_scr_ok = (k < WORD_W'(SCRATCH_WORDS));
  assign k_scr    = k[SW-1:0];

  // Memories
  always_ff @(posedge clk) begin
    if (prog_wr) prog_mem[PW'(in_instr_index)] <= {in_instr_code, in_jump_true,
                                                     in_jump_false, in_constant_k};
    if (state_r == S_FETCH) insn_q_r <= prog_mem[pc_r[PW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (byte_wr) pkt_mem[pkt_len_r[AW-1:0]] <= in_data_byte;
    if (state_r == S_LDADDR) pkt_q_r <= pkt_mem[ld_addr_r];
  end

  logic scr_we;
  assign scr_we = (state_r == S_EXEC) && ((code == OP_ST) || (code == OP_STX)) && k_scr_ok;
  always_ff @(posedge clk) begin
    if (scr_we) scr_mem[k_scr] <= (code == OP_STX) ? x_r : a_r;
    if (state_r == S_EXEC) scr_q_r <= scr_mem[k_scr];
  end

  // Sequencer, registers and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      plen_r      <= PLEN_W'(1);
      pkt_len_r   <= '0;
      pc_r        <= '0;
      a_r         <= '0;
      x_r         <= '0;
      out_valid_r <= 1'b0;
      scr_vld_r   <= '0;
      div_cnt_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) plen_r <= cfg_data;
      if (out_valid_r && !out_stall && (state_r != S_DONE)) out_valid_r <= 1'b0;
      if (byte_wr) pkt_len_r <= pkt_len_r + LW'(1);
      if (scr_we) scr_vld_r[k_scr] <= 1'b1;

      unique case (state_r)
        S_IDLE: begin
          if (run_start) begin
            pc_r      <= '0;
            a_r       <= '0;
            x_r       <= '0;
            scr_vld_r <= '0;
            state_r   <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (pc_r >= limit) begin
            result_r <= '0;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          pc_r <= pc_nxt;
          if (code[15:8] == 8'h00 && !code[7] && code[2:0] == CLS_ALU) begin
            if (opf == ALU_DIV) begin
              if (t == '0) begin
                result_r <= '0;
                state_r  <= S_DONE;
              end else begin
                div_rem_r <= '0;
                div_quo_r <= a_r;
                div_dvs_r <= t;
                div_cnt_r <= '0;
                state_r   <= S_DIV;
              end
            end else begin
              a_r     <= alu_y;
              state_r <= S_FETCH;
            end
          end else begin
            case (code)
              OP_RET_K: begin result_r <= k;   state_r <= S_DONE; end
              OP_RET_A: begin result_r <= a_r; state_r <= S_DONE; end
              OP_LD_ABS_W, OP_LD_ABS_H, OP_LD_ABS_B,
              OP_LD_IND_W, OP_LD_IND_H, OP_LD_IND_B, OP_LDX_MSH: begin
                if (ld_end > PC_W'(pkt_len_r)) begin
                  result_r <= '0;
                  state_r  <= S_DONE;
                end else begin
                  ld_addr_r <= ld_off[AW-1:0];
                  ld_left_r <= ld_size;
                  ld_val_r  <= '0;
                  ld_to_x_r <= (code == OP_LDX_MSH);
                  ld_msh_r  <= (code == OP_LDX_MSH);
                  state_r   <= S_LDADDR;
                end
              end
              OP_LD_LEN:  begin a_r <= WORD_W'(pkt_len_r); state_r <= S_FETCH; end
              OP_LDX_LEN: begin x_r <= WORD_W'(pkt_len_r); state_r <= S_FETCH; end
              OP_LD_IMM:  begin a_r <= k; state_r <= S_FETCH; end
              OP_LDX_IMM: begin x_r <= k; state_r <= S_FETCH; end
              OP_LD_MEM, OP_LDX_MEM: begin
                if (!k_scr_ok) begin
                  result_r <= '0;
                  state_r  <= S_DONE;
                end else begin
                  scr_qv_r  <= scr_vld_r[k_scr];
                  ld_to_x_r <= (code == OP_LDX_MEM);
                  state_r   <= S_SCR;
                end
              end
              OP_ST, OP_STX: begin
                if (!k_scr_ok) begin
                  result_r <= '0;
                  state_r  <= S_DONE;
                end else begin
                  state_r <= S_FETCH;
                end
              end
              OP_JA, OP_JEQ_K, OP_JEQ_X, OP_JGT_K, OP_JGT_X,
              OP_JGE_K, OP_JGE_X, OP_JSET_K, OP_JSET_X:
                state_r <= S_FETCH;
              OP_NEG: begin a_r <= '0 - a_r; state_r <= S_FETCH; end
              OP_TAX: begin x_r <= a_r; state_r <= S_FETCH; end
              OP_TXA: begin a_r <= x_r; state_r <= S_FETCH; end
              default: begin
                result_r <= '0;
                state_r  <= S_DONE;
              end
            endcase
          end
        end
        S_LDADDR: state_r <= S_LDDATA;
        S_LDDATA: begin
          ld_val_r  <= {ld_val_r[WORD_W-9:0], pkt_q_r};
          ld_addr_r <= ld_addr_r + AW'(1);
          ld_left_r <= ld_left_r - 3'd1;
          if (ld_left_r == SZ_B) begin
            state_r <= S_FETCH;
            if (ld_msh_r) x_r <= WORD_W'({pkt_q_r[3:0] & NIB_MASK, 2'b00});
            else          a_r <= {ld_val_r[WORD_W-9:0], pkt_q_r};
          end else begin
            state_r <= S_LDADDR;
          end
        end
        S_SCR: begin
          if (ld_to_x_r) x_r <= scr_qv_r ? scr_q_r : '0;
          else           a_r <= scr_qv_r ? scr_q_r : '0;
          state_r <= S_FETCH;
        end
        S_DIV: begin
          // Restoring divide, one quotient bit per cycle
          if (!div_trial[WORD_W]) begin
            div_rem_r <= div_trial[WORD_W-1:0];
            div_quo_r <= {div_quo_r[WORD_W-2:0], 1'b1};
          end else begin
            div_rem_r <= {div_rem_r[WORD_W-2:0], div_quo_r[WORD_W-1]};
            div_quo_r <= {div_quo_r[WORD_W-2:0], 1'b0};
          end
          div_cnt_r <= div_cnt_r + DCW'(1);
          if (div_cnt_r == DCW'(WORD_W - 1)) begin
            a_r     <= {div_quo_r[WORD_W-2:0], !div_trial[WORD_W]};
            state_r <= S_FETCH;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_value_r <= result_r;
            pkt_len_r   <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_return_value = out_value_r;
  assign out_accepted     = (out_value_r != '0);

  // Checks
  a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
    run_start |=> (state_r == S_FETCH) && (pc_r == '0) && (scr_vld_r == '0))
    else $error("run did not start cleanly");
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_len_r <= LW'(PACKET_BYTES))
    else $error("packet length beyond buffer");
  a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && !out_stall |=> out_valid_r && (state_r == S_IDLE))
    else $error("verdict not delivered");
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_dvs_r != '0))
    else $error("divide by zero entered divider");
  a_load_size: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LDADDR) |-> (ld_left_r != 3'd0) && (ld_left_r <= SZ_W))
    else $error("load byte count out of range");

endmodule
`default_nettype wire
